>>> hdl/kdt_pkg.sv
// ----------------------------------------------------------------------------
// kdt_pkg
// Types, sizes and codes shared by the kd-tree insert/delete unit, its port
// checker and its testbench.
// ----------------------------------------------------------------------------
package kdt_pkg;

  localparam int unsigned MAX_NODES  = 1024;
  localparam int unsigned IDX_W      = $clog2(MAX_NODES);
  localparam int unsigned CNT_W      = $clog2(MAX_NODES + 1);
  localparam int unsigned LINK_W     = $clog2(MAX_NODES + 1);
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned NODE_IDX_W = 10;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_DELETE = 1'b1
  } kdt_mode_e;

  typedef enum logic [2:0] {
    STATUS_INSERTED  = 3'd0,
    STATUS_DUPLICATE = 3'd1,
    STATUS_DELETED   = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_FULL      = 3'd4
  } kdt_status_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } kdt_axis_e;

  typedef enum logic [2:0] {
    KDT_IDLE,
    KDT_START,
    KDT_WALK,
    KDT_LINK,
    KDT_DONE
  } kdt_state_e;

  typedef struct packed {
    kdt_mode_e                  mode;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
  } kdt_in_t;

  typedef struct packed {
    kdt_status_e             status;
    logic [NODE_IDX_W-1:0]   node_index;
  } kdt_out_t;

  // one node store entry
  typedef struct packed {
    logic                       deleted;
    kdt_axis_e                  axis;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
  } kdt_node_t;

  // child links hold index plus one, zero for no child
  typedef struct packed {
    logic [LINK_W-1:0] left;
    logic [LINK_W-1:0] right;
  } kdt_link_t;

  function automatic kdt_axis_e next_axis(kdt_axis_e axis);
    kdt_axis_e res;
    case (axis)
      AXIS_X:  res = AXIS_Y;
      AXIS_Y:  res = AXIS_Z;
      default: res = AXIS_X;
    endcase
    return res;
  endfunction

endpackage

>>> hdl/kdt_ram.sv
// ----------------------------------------------------------------------------
// kdt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module kdt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/kd_tree_point_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// kd_tree_point_insert_delete_unit
// 3-D kd-tree keeper: inserts points as new leaves or marks matching points
// deleted, walking the tree from the root one node per cycle.
// ----------------------------------------------------------------------------
// One request word is taken at a time. From acceptance, a request passes
// through START, one WALK step for each of the d nodes visited on the path
// from the root (d between 1 and the tree depth), LINK for an insert that
// appends a node, and DONE; a request on an empty store goes from START
// straight to DONE. The walk is set by the node store's single read port:
// one node is read and compared per cycle by one shared compare unit, and
// the next address comes from the child link just read. An appending insert
// needs LINK because the parent's link word and the new node share the link
// memory's one write port. The store needs no clearing pass after reset:
// only entries below the node count are ever read. A finished result sits in
// an output register, and the next request is taken once it is loaded there.
module kd_tree_point_insert_delete_unit
  import kdt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  kdt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output kdt_out_t out_data_o
);

  kdt_state_e        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;
  kdt_in_t           req_q, req_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [IDX_W-1:0]  new_idx_q, new_idx_d;
  logic              lt_q, lt_d;
  kdt_link_t         plink_q, plink_d;
  kdt_out_t          res_q, res_d;
  kdt_out_t          out_q, out_d;

  // node store ports
  logic              node_we, link_we, rd_en;
  logic [IDX_W-1:0]  node_waddr, link_waddr, rd_addr;
  kdt_node_t         node_wdata, node_rd;
  kdt_link_t         link_wdata, link_rd;

  // compare unit
  logic signed [COORD_W-1:0] key, pnt;
  logic              lt, match, child_none, full, is_insert;
  logic [LINK_W-1:0] next_link, new_link;

  kdt_ram #(
    .WIDTH ($bits(kdt_node_t)),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (node_rd)
  );

  kdt_ram #(
    .WIDTH ($bits(kdt_link_t)),
    .DEPTH (MAX_NODES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (link_rd)
  );

  always_comb begin
    case (node_rd.axis)
      AXIS_X: begin
        key = node_rd.x;
        pnt = req_q.coord_x;
      end
      AXIS_Y: begin
        key = node_rd.y;
        pnt = req_q.coord_y;
      end
      default: begin
        key = node_rd.z;
        pnt = req_q.coord_z;
      end
    endcase
  end

  assign lt         = pnt < key;
  assign match      = (node_rd.x == req_q.coord_x) && (node_rd.y == req_q.coord_y) &&
                      (node_rd.z == req_q.coord_z);
  assign next_link  = lt ? link_rd.left : link_rd.right;
  assign child_none = (next_link == '0);
  assign full       = (count_q == CNT_W'(MAX_NODES));
  assign is_insert  = (req_q.mode == MODE_INSERT);
  assign new_link   = LINK_W'(new_idx_q) + LINK_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      KDT_IDLE: begin
        if (in_valid_i) begin
          state_d = KDT_START;
        end
      end
      KDT_START: begin
        state_d = (count_q == '0) ? KDT_DONE : KDT_WALK;
      end
      KDT_WALK: begin
        if (match) begin
          state_d = KDT_DONE;
        end else if (child_none) begin
          state_d = (is_insert && !full) ? KDT_LINK : KDT_DONE;
        end
      end
      KDT_LINK: begin
        state_d = KDT_DONE;
      end
      KDT_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = KDT_IDLE;
        end
      end
      default: state_d = KDT_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_d       = req_q;
    cur_d       = cur_q;
    count_d     = count_q;
    new_idx_d   = new_idx_q;
    lt_d        = lt_q;
    plink_d     = plink_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    node_we     = 1'b0;
    node_waddr  = cur_q;
    node_wdata  = node_rd;
    link_we     = 1'b0;
    link_waddr  = cur_q;
    link_wdata  = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;

    unique case (state_q)
      KDT_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
        end
      end
      KDT_START: begin
        res_d.node_index = '0;
        if (count_q == '0) begin
          if (is_insert) begin
            // empty store: the point becomes the root
            node_we      = 1'b1;
            node_waddr   = '0;
            node_wdata   = '{deleted: 1'b0, axis: AXIS_X, x: req_q.coord_x,
                             y: req_q.coord_y, z: req_q.coord_z};
            link_we      = 1'b1;
            link_waddr   = '0;
            count_d      = CNT_W'(1);
            res_d.status = STATUS_INSERTED;
          end else begin
            res_d.status = STATUS_NOT_FOUND;
          end
        end else begin
          rd_en = 1'b1;
          cur_d = '0;
        end
      end
      KDT_WALK: begin
        if (match) begin
          res_d.node_index = NODE_IDX_W'(cur_q);
          if (is_insert) begin
            res_d.status = STATUS_DUPLICATE;
          end else begin
            res_d.status       = STATUS_DELETED;
            node_we            = 1'b1;
            node_wdata.deleted = 1'b1;
          end
        end else if (child_none) begin
          res_d.node_index = '0;
          if (!is_insert) begin
            res_d.status = STATUS_NOT_FOUND;
          end else if (full) begin
            res_d.status = STATUS_FULL;
          end else begin
            // append leaf now, hook it to the parent next cycle
            node_we          = 1'b1;
            node_waddr       = IDX_W'(count_q);
            node_wdata       = '{deleted: 1'b0, axis: next_axis(node_rd.axis),
                                 x: req_q.coord_x, y: req_q.coord_y, z: req_q.coord_z};
            link_we          = 1'b1;
            link_waddr       = IDX_W'(count_q);
            count_d          = count_q + CNT_W'(1);
            new_idx_d        = IDX_W'(count_q);
            lt_d             = lt;
            plink_d          = link_rd;
            res_d.status     = STATUS_INSERTED;
            res_d.node_index = NODE_IDX_W'(count_q);
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(next_link - LINK_W'(1));
          cur_d   = IDX_W'(next_link - LINK_W'(1));
        end
      end
      KDT_LINK: begin
        link_we    = 1'b1;
        link_wdata = plink_q;
        if (lt_q) begin
          link_wdata.left = new_link;
        end else begin
          link_wdata.right = new_link;
        end
      end
      KDT_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= KDT_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    cur_q     <= cur_d;
    new_idx_q <= new_idx_d;
    lt_q      <= lt_d;
    plink_q   <= plink_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign in_ready_o  = (state_q == KDT_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/kdt_checker.sv
// ----------------------------------------------------------------------------
// kdt_checker
// Port-level checks for the kd-tree insert/delete unit, bound to the top.
// ----------------------------------------------------------------------------
module kdt_checker
  import kdt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input kdt_out_t out_data_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // one request at a time: busy right after a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while a walk is running");

  // no result can appear in the cycle right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // results without a node carry index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_NOT_FOUND ||
                    out_data_o.status == STATUS_FULL)
    |-> out_data_o.node_index == '0)
    else $error("nonzero index on a result without a node");

endmodule

bind kd_tree_point_insert_delete_unit kdt_checker u_kdt_checker (.*);

>>> dv/kdt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdt_tb_checker
// Watches both ports of the kd-tree insert/delete unit, keeps its own copy of
// the node store, predicts the status and node index of every request word
// and compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module kdt_tb_checker
  import kdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  kdt_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  kdt_out_t    out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned nodes_o,
  output int unsigned full_hits_o
);

  // shadow node store
  logic signed [COORD_W-1:0] tree_x [MAX_NODES];
  logic signed [COORD_W-1:0] tree_y [MAX_NODES];
  logic signed [COORD_W-1:0] tree_z [MAX_NODES];
  int unsigned               tree_left [MAX_NODES];
  int unsigned               tree_right [MAX_NODES];
  kdt_axis_e                 tree_axis [MAX_NODES];
  logic                      tree_del [MAX_NODES];
  int unsigned               tree_size = 0;

  kdt_out_t    pending_results_q[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned full_hits = 0;

  assign fail_count_o = mismatches;
  assign results_o    = results_seen;
  assign nodes_o      = tree_size;
  assign full_hits_o  = full_hits;

  function automatic void store_node(int unsigned idx, kdt_in_t req, kdt_axis_e axis);
    tree_x[idx]     = req.coord_x;
    tree_y[idx]     = req.coord_y;
    tree_z[idx]     = req.coord_z;
    tree_left[idx]  = 0;
    tree_right[idx] = 0;
    tree_axis[idx]  = axis;
    tree_del[idx]   = 1'b0;
    tree_size       = tree_size + 1;
  endfunction

  // walks from the root and applies the request to the shadow store
  function automatic kdt_out_t apply_to_tree(kdt_in_t req);
    kdt_out_t                  res;
    int unsigned               cur;
    int unsigned               visits;
    int unsigned               link;
    logic signed [COORD_W-1:0] pt;
    logic signed [COORD_W-1:0] key;
    logic                      go_left;
    logic                      done;
    kdt_axis_e                 nxt;
    res.status     = STATUS_NOT_FOUND;
    res.node_index = '0;
    if (tree_size == 0) begin
      if (req.mode == MODE_INSERT) begin
        store_node(0, req, AXIS_X);
        res.status = STATUS_INSERTED;
      end
    end else begin
      cur    = 0;
      visits = 0;
      done   = 1'b0;
      while (!done && visits < MAX_NODES && cur < tree_size) begin
        visits++;
        if (tree_x[cur] == req.coord_x && tree_y[cur] == req.coord_y &&
            tree_z[cur] == req.coord_z) begin
          // deleted mark is not part of the match
          res.node_index = cur[NODE_IDX_W-1:0];
          if (req.mode == MODE_INSERT) begin
            res.status = STATUS_DUPLICATE;
          end else begin
            tree_del[cur] = 1'b1;
            res.status    = STATUS_DELETED;
          end
          done = 1'b1;
        end else begin
          case (tree_axis[cur])
            AXIS_X: begin
              pt  = req.coord_x;
              key = tree_x[cur];
              nxt = AXIS_Y;
            end
            AXIS_Y: begin
              pt  = req.coord_y;
              key = tree_y[cur];
              nxt = AXIS_Z;
            end
            default: begin
              pt  = req.coord_z;
              key = tree_z[cur];
              nxt = AXIS_X;
            end
          endcase
          // ties go right
          go_left = pt < key;
          link    = go_left ? tree_left[cur] : tree_right[cur];
          if (link == 0) begin
            done = 1'b1;
            if (req.mode == MODE_INSERT) begin
              if (tree_size >= MAX_NODES) begin
                res.status = STATUS_FULL;
                full_hits++;
              end else begin
                res.node_index = tree_size[NODE_IDX_W-1:0];
                if (go_left) begin
                  tree_left[cur] = tree_size + 1;
                end else begin
                  tree_right[cur] = tree_size + 1;
                end
                store_node(tree_size, req, nxt);
                res.status = STATUS_INSERTED;
              end
            end
          end else begin
            cur = link - 1;
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin : port_watch
    kdt_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        pending_results_q.insert(pending_results_q.size(), apply_to_tree(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (pending_results_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result word: status %0d index %0d",
                     out_data_i.status, out_data_i.node_index);
          end
          mismatches++;
        end else begin
          want = pending_results_q.pop_front();
          if (out_data_i.status !== want.status ||
              out_data_i.node_index !== want.node_index) begin
            if (mismatches < 10) begin
              $display("result word %0d: expected status %0d index %0d, got status %0d index %0d",
                       results_seen, want.status, want.node_index,
                       out_data_i.status, out_data_i.node_index);
            end
            mismatches++;
          end
        end
      end
      pending_o <= pending_results_q.size();
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert and delete requests into the kd-tree unit with random gaps
// and output stalls; a directed opening covers coordinate extremes, ties,
// duplicates and repeated deletes, then random traffic fills the store past
// its capacity. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module testbench;
  import kdt_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned RANDOM_WORDS = 560;   // per idling phase
  localparam int unsigned TAIL_CYCLES  = 64;

  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  kdt_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  kdt_out_t out_data_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;
  int unsigned nodes;
  int unsigned full_hits;

  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 71;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  kdt_in_t     sent_points[$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  kd_tree_point_insert_delete_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  kdt_tb_checker u_tb_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .nodes_o      (nodes),
    .full_hits_o  (full_hits)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("kd_tree_point_insert_delete_unit verification failed");
      $finish;
    end
  end

  // mostly full-range values, with extremes and a tight cluster near zero for ties
  function automatic logic signed [COORD_W-1:0] pick_coord();
    int unsigned sel;
    logic signed [COORD_W-1:0] c;
    sel = $urandom_range(9);
    if (sel == 0) begin
      c = C_MIN;
    end else if (sel == 1) begin
      c = C_MAX;
    end else if (sel <= 3) begin
      c = $signed({28'd0, 4'($urandom_range(4))}) - 2;
    end else begin
      c = $urandom;
    end
    return c;
  endfunction

  task automatic send_request(input kdt_mode_e mode, input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic signed [COORD_W-1:0] z);
    kdt_in_t w;
    w.mode    = mode;
    w.coord_x = x;
    w.coord_y = y;
    w.coord_z = z;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (mode == MODE_INSERT) begin
      sent_points.insert(sent_points.size(), w);
    end
  endtask

  // hold off until every outstanding result word has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned pick;
    kdt_in_t     known;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening
    send_request(MODE_DELETE, 0, 0, 0);            // delete on empty store
    send_request(MODE_INSERT, 0, 0, 0);            // root
    send_request(MODE_INSERT, C_MAX, C_MAX, C_MAX);
    send_request(MODE_INSERT, C_MIN, C_MIN, C_MIN);
    send_request(MODE_INSERT, C_MIN, C_MAX, 0);
    send_request(MODE_INSERT, C_MAX, C_MIN, -1);
    send_request(MODE_INSERT, -1, -1, -1);
    send_request(MODE_INSERT, 0, 5, 5);            // tie with root on x
    send_request(MODE_INSERT, 0, 5, -5);
    send_request(MODE_INSERT, 0, 0, 0);            // duplicate of root
    send_request(MODE_DELETE, C_MAX, C_MAX, C_MAX);
    send_request(MODE_DELETE, C_MAX, C_MAX, C_MAX); // already deleted
    send_request(MODE_INSERT, C_MAX, C_MAX, C_MAX); // reinsert of deleted point
    send_request(MODE_DELETE, 1, 2, 3);            // absent point
    send_request(MODE_DELETE, 0, 0, 0);            // root
    send_request(MODE_DELETE, -1, -1, -1);
    send_request(MODE_INSERT, 32'sh0000_8000, 32'shffff_8000, 32'sh5555_aaaa);
    send_request(MODE_INSERT, 32'shaaaa_5555, 32'sh3333_cccc, 32'shcccc_3333);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_WORDS; n++) begin
        pick  = $urandom_range(99);
        known = sent_points[$urandom_range(sent_points.size() - 1)];
        if (pick < 72) begin
          send_request(MODE_INSERT, pick_coord(), pick_coord(), pick_coord());
        end else if (pick < 80) begin
          send_request(MODE_INSERT, known.coord_x, known.coord_y, known.coord_z);
        end else if (pick < 92) begin
          send_request(MODE_DELETE, known.coord_x, known.coord_y, known.coord_z);
        end else begin
          send_request(MODE_DELETE, pick_coord(), pick_coord(), pick_coord());
        end
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("sent %0d request words, checked %0d result words", words_sent, results);
    $display("store reached %0d nodes, %0d inserts refused as full", nodes, full_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("kd_tree_point_insert_delete_unit verification clean");
    end else begin
      $display("kd_tree_point_insert_delete_unit verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/kdt_pkg.sv
hdl/kdt_ram.sv
hdl/kd_tree_point_insert_delete_unit.sv
hdl/kdt_checker.sv
dv/kdt_checker.sv
dv/testbench.sv
